// File: rtl/deq_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// deq_pkg: shared types and constants for the double-ended queue
// Capacity, field widths, command and status codes, payload and control
// structs used by the controller, datapath and top level.
// ----------------------------------------------------------------------------
package deq_pkg;

    localparam int CAPACITY = 16;
    localparam int PTR_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int VALUE_W  = 32;
    localparam int COUNT_W  = 5;

    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(CAPACITY - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(CAPACITY);

    localparam logic signed [VALUE_W-1:0] INT_MIN = 32'sh8000_0000;

    localparam logic [2:0] CMD_NONE       = 3'd0;
    localparam logic [2:0] CMD_PUSH_REAR  = 3'd1;
    localparam logic [2:0] CMD_PUSH_FRONT = 3'd2;
    localparam logic [2:0] CMD_POP_REAR   = 3'd3;
    localparam logic [2:0] CMD_POP_FRONT  = 3'd4;
    localparam logic [2:0] CMD_CLEAR      = 3'd5;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    typedef struct packed {
        logic [2:0]                command;
        logic signed [VALUE_W-1:0] value;
    } t_in;

    typedef struct packed {
        logic signed [VALUE_W-1:0] front_value;
        logic signed [VALUE_W-1:0] rear_value;
        logic [COUNT_W-1:0]        count;
        logic                      is_empty;
        logic [1:0]                status;
    } t_out;

    // controller -> datapath
    typedef struct packed {
        logic latch;     // capture the input item
        logic exec;      // update pointers and count, write the ring
        logic rd_en;     // read front and rear slots
        logic load_out;  // move the read data into the output register
    } t_deq_ctl;

    // datapath -> controller
    typedef struct packed {
        logic out_free;  // output register can take a new item this cycle
    } t_deq_stat;

    function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] i);
        return (i == PTR_LAST) ? '0 : i + PTR_W'(1);
    endfunction

    function automatic logic [PTR_W-1:0] ring_prev(input logic [PTR_W-1:0] i);
        return (i == '0) ? PTR_LAST : i - PTR_W'(1);
    endfunction

endpackage
`default_nettype wire

// File: rtl/deq_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// deq_ram: generic RAM
// One write port, two read ports, read data registered on a read enable.
// ----------------------------------------------------------------------------
module deq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic      [WIDTH-1:0]         o_rdata_a,
    output logic      [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata_a <= r_mem[i_raddr_a];
            o_rdata_b <= r_mem[i_raddr_b];
        end
    end

endmodule
`default_nettype wire

// File: rtl/deq_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// deq_ctrl: sequencing state machine
// Steps each item through capture, update, ring read and output load.
// ----------------------------------------------------------------------------
module deq_ctrl (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_ready,
    input  wire deq_pkg::t_deq_stat i_stat,
    output deq_pkg::t_deq_ctl       o_ctl
);
    import deq_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_EXEC = 4'b0010,
        S_READ = 4'b0100,
        S_LOAD = 4'b1000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) n_state = S_EXEC;
            end
            S_EXEC: n_state = S_READ;
            S_READ: n_state = S_LOAD;
            S_LOAD: begin
                if (i_stat.out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_ready        = (r_state == S_IDLE);
    assign o_ctl.latch    = (r_state == S_IDLE) && i_valid;
    assign o_ctl.exec     = (r_state == S_EXEC);
    assign o_ctl.rd_en    = (r_state == S_READ);
    assign o_ctl.load_out = (r_state == S_LOAD) && i_stat.out_free;

`ifndef SYNTH
    a_accept_to_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> o_ctl.exec)
        else $error("accepted item did not move to update");
    a_exec_to_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ctl.exec |=> o_ctl.rd_en)
        else $error("update not followed by ring read");
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_ctl.exec || o_ctl.rd_en) |-> !o_ready)
        else $error("ready raised while an item is in flight");
`endif

endmodule
`default_nettype wire

// File: rtl/deq_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// deq_dp: deque datapath
// Head/tail pointers, count, ring store and the output register.
// ----------------------------------------------------------------------------
module deq_dp (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire deq_pkg::t_in       i_data,
    input  wire deq_pkg::t_deq_ctl  i_ctl,
    output deq_pkg::t_deq_stat      o_stat,
    output logic                    o_valid,
    input  wire logic               i_ready,
    output deq_pkg::t_out           o_data
);
    import deq_pkg::*;

    logic [2:0]                r_cmd;
    logic signed [VALUE_W-1:0] r_value;
    logic [PTR_W-1:0]          r_head, n_head;
    logic [PTR_W-1:0]          r_tail, n_tail;
    logic [CNT_W-1:0]          r_count, n_count;
    logic [1:0]                r_status, n_status;
    logic                      ram_we;
    logic [PTR_W-1:0]          ram_waddr;
    logic [VALUE_W-1:0]        rdata_front;
    logic [VALUE_W-1:0]        rdata_rear;
    logic                      r_out_valid;
    t_out                      r_out;

    always_ff @(posedge i_clk) begin
        if (i_ctl.latch) begin
            r_cmd   <= i_data.command;
            r_value <= i_data.value;
        end
    end

    always_comb begin
        n_head    = r_head;
        n_tail    = r_tail;
        n_count   = r_count;
        n_status  = ST_OK;
        ram_we    = 1'b0;
        ram_waddr = r_tail;
        case (r_cmd)
            CMD_PUSH_REAR: begin
                if (r_count >= CNT_FULL) begin
                    n_status = ST_FULL;
                end else begin
                    ram_we  = 1'b1;
                    n_tail  = ring_next(r_tail);
                    n_count = r_count + CNT_W'(1);
                end
            end
            CMD_PUSH_FRONT: begin
                if (r_count >= CNT_FULL) begin
                    n_status = ST_FULL;
                end else begin
                    ram_we    = 1'b1;
                    ram_waddr = ring_prev(r_head);
                    n_head    = ring_prev(r_head);
                    n_count   = r_count + CNT_W'(1);
                end
            end
            CMD_POP_REAR: begin
                if (r_count == '0) begin
                    n_status = ST_EMPTY;
                end else begin
                    n_tail  = ring_prev(r_tail);
                    n_count = r_count - CNT_W'(1);
                end
            end
            CMD_POP_FRONT: begin
                if (r_count == '0) begin
                    n_status = ST_EMPTY;
                end else begin
                    n_head  = ring_next(r_head);
                    n_count = r_count - CNT_W'(1);
                end
            end
            CMD_CLEAR: begin
                n_head  = '0;
                n_tail  = '0;
                n_count = '0;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else if (i_ctl.exec) begin
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.exec) begin
            r_status <= n_status;
        end
    end

    // rear value sits one slot behind the tail
    deq_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .i_clk     (i_clk),
        .i_we      (i_ctl.exec && ram_we),
        .i_waddr   (ram_waddr),
        .i_wdata   (r_value),
        .i_re      (i_ctl.rd_en),
        .i_raddr_a (r_head),
        .i_raddr_b (ring_prev(r_tail)),
        .o_rdata_a (rdata_front),
        .o_rdata_b (rdata_rear)
    );

    assign o_stat.out_free = !r_out_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_ctl.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load_out) begin
            r_out.front_value <= (r_count != '0) ? $signed(rdata_front) : INT_MIN;
            r_out.rear_value  <= (r_count != '0) ? $signed(rdata_rear) : INT_MIN;
            r_out.count       <= COUNT_W'(r_count);
            r_out.is_empty    <= (r_count == '0);
            r_out.status      <= r_status;
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

`ifndef SYNTH
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_FULL)
        else $error("count above capacity");
    a_clear_resets: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_ctl.exec && r_cmd == CMD_CLEAR) |=>
        (r_count == '0 && r_head == '0 && r_tail == '0))
        else $error("clear left pointers or count set");
    a_full_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_ctl.exec && r_count == CNT_FULL &&
         (r_cmd == CMD_PUSH_REAR || r_cmd == CMD_PUSH_FRONT)) |=>
        ($stable(r_count) && $stable(r_head) && $stable(r_tail)))
        else $error("push into full deque changed state");
`endif

endmodule
`default_nettype wire

// File: rtl/double_ended_queue_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// double_ended_queue_core: bounded deque of signed 32-bit values
// Ring-store deque with push/pop at both ends, clear, and a status report
// per command.
// ----------------------------------------------------------------------------
// Each command item produces one result item: front and rear values (most
// negative value when empty), count, empty flag and status (push into a full
// deque is dropped, pop from an empty one ignored). The item is captured at
// acceptance, then goes through the pointer/count update with the ring write,
// a registered ring read of the front and rear slots, and the output register
// load. Ready returns the cycle after that load, so no new item is taken while
// one is in flight. The load waits while the output register still holds a
// result that has not been taken. The output register lets the next item
// start while a result waits downstream.
// ----------------------------------------------------------------------------
module double_ended_queue_core (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_ready,
    input  wire deq_pkg::t_in  i_data,
    output logic               o_valid,
    input  wire logic          i_ready,
    output deq_pkg::t_out      o_data
);
    import deq_pkg::*;

    t_deq_ctl  ctl;
    t_deq_stat stat;

    deq_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_stat  (stat),
        .o_ctl   (ctl)
    );

    deq_dp u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_data  (i_data),
        .i_ctl   (ctl),
        .o_stat  (stat),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_data  (o_data)
    );

endmodule
`default_nettype wire

// File: dv/double_ended_queue_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// double_ended_queue_checker: scoreboard for the double-ended queue
// Watches the command and result channels. Every accepted command runs through
// a ring-store deque of its own, and the result it predicts is queued. Every
// accepted result is compared field by field with the oldest queued one.
// ----------------------------------------------------------------------------
module double_ended_queue_checker (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_cmd_valid,
    input  wire logic          i_cmd_ready,
    input  wire deq_pkg::t_in  i_cmd_item,
    input  wire logic          i_res_valid,
    input  wire logic          i_res_ready,
    input  wire deq_pkg::t_out i_res_item,
    output int                 o_errors,
    output int                 o_pending,
    output int                 o_results,
    output int                 o_full_drops,
    output int                 o_empty_pops,
    output int                 o_full_steps,
    output int                 o_clears
);
    import deq_pkg::*;

    localparam int MAX_REPORTS = 10;

    logic signed [VALUE_W-1:0] slots [CAPACITY];
    int   head_slot;
    int   tail_slot;
    int   fill;
    t_out deque_results_q [$];

    // one command applied to the predicted deque, returns the report it gives
    function automatic t_out deque_step(input t_in item);
        t_out r;
        r.status = ST_OK;
        case (item.command)
            CMD_PUSH_REAR: begin
                if (fill >= CAPACITY) begin
                    r.status = ST_FULL;
                end else begin
                    slots[tail_slot] = item.value;
                    tail_slot = (tail_slot + 1) % CAPACITY;
                    fill++;
                end
            end
            CMD_PUSH_FRONT: begin
                if (fill >= CAPACITY) begin
                    r.status = ST_FULL;
                end else begin
                    head_slot = (head_slot + CAPACITY - 1) % CAPACITY;
                    slots[head_slot] = item.value;
                    fill++;
                end
            end
            CMD_POP_REAR: begin
                if (fill == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    tail_slot = (tail_slot + CAPACITY - 1) % CAPACITY;
                    fill--;
                end
            end
            CMD_POP_FRONT: begin
                if (fill == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    head_slot = (head_slot + 1) % CAPACITY;
                    fill--;
                end
            end
            CMD_CLEAR: begin
                head_slot = 0;
                tail_slot = 0;
                fill      = 0;
            end
            default: ;
        endcase
        r.count    = COUNT_W'(fill);
        r.is_empty = (fill == 0);
        if (fill == 0) begin
            r.front_value = INT_MIN;
            r.rear_value  = INT_MIN;
        end else begin
            r.front_value = slots[head_slot];
            r.rear_value  = slots[(tail_slot + CAPACITY - 1) % CAPACITY];
        end
        return r;
    endfunction

    initial begin
        foreach (slots[k]) slots[k] = '0;
        head_slot = 0;
        tail_slot = 0;
        fill      = 0;
    end

    always @(posedge i_clk) begin
        t_out  want;
        string bad;
        if (!i_rst_n) begin
            head_slot = 0;
            tail_slot = 0;
            fill      = 0;
            deque_results_q.delete();
        end else begin
            // results first: a result never belongs to a command of the same edge
            if (i_res_valid && i_res_ready) begin
                if (deque_results_q.size() == 0) begin
                    o_errors++;
                    if (o_errors <= MAX_REPORTS)
                        $display({"ERROR: result with nothing pending: ",
                                  "front=%0d rear=%0d count=%0d empty=%0b status=%0d"},
                                 i_res_item.front_value, i_res_item.rear_value,
                                 i_res_item.count, i_res_item.is_empty, i_res_item.status);
                end else begin
                    want = deque_results_q.pop_front();
                    bad  = "";
                    if (i_res_item.front_value !== want.front_value) bad = {bad, " front_value"};
                    if (i_res_item.rear_value  !== want.rear_value)  bad = {bad, " rear_value"};
                    if (i_res_item.count       !== want.count)       bad = {bad, " count"};
                    if (i_res_item.is_empty    !== want.is_empty)    bad = {bad, " is_empty"};
                    if (i_res_item.status      !== want.status)      bad = {bad, " status"};
                    o_results++;
                    if (bad != "") begin
                        o_errors++;
                        if (o_errors <= MAX_REPORTS) begin
                            $display("ERROR: result %0d differs in%s", o_results, bad);
                            $display("  exp front=%0d rear=%0d count=%0d empty=%0b status=%0d",
                                     want.front_value, want.rear_value, want.count,
                                     want.is_empty, want.status);
                            $display("  got front=%0d rear=%0d count=%0d empty=%0b status=%0d",
                                     i_res_item.front_value, i_res_item.rear_value,
                                     i_res_item.count, i_res_item.is_empty, i_res_item.status);
                        end
                    end
                end
            end
            if (i_cmd_valid && i_cmd_ready) begin
                want = deque_step(i_cmd_item);
                deque_results_q.push_back(want);
                if (want.status == ST_FULL)  o_full_drops++;
                if (want.status == ST_EMPTY) o_empty_pops++;
                if (fill == CAPACITY)        o_full_steps++;
                if (i_cmd_item.command == CMD_CLEAR) o_clears++;
            end
        end
        o_pending = deque_results_q.size();
    end

endmodule
`default_nettype wire

// File: dv/double_ended_queue_core_tb.sv
`default_nettype none
// ----------------------------------------------------------------------------
// double_ended_queue_core_tb: testbench top for the double-ended queue
// Drives commands in bursts with random gaps, stalls the result side on its
// own pattern, and leaves prediction and comparison to the checker. Starts
// with the corner cases, then runs fill-heavy, drain-heavy and mixed phases.
// ----------------------------------------------------------------------------
module double_ended_queue_core_tb;
    import deq_pkg::*;

    localparam int TOTAL_ITEMS    = 1250;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 16;

    // codes the block treats as no operation
    localparam logic [2:0] CMD_SPARE_6 = 3'd6;
    localparam logic [2:0] CMD_SPARE_7 = 3'd7;

    localparam logic signed [VALUE_W-1:0] INT_MAX = ~INT_MIN;

    localparam int BIAS_FILL  = 0;
    localparam int BIAS_DRAIN = 1;
    localparam int BIAS_MIXED = 2;

    localparam int RX_ALWAYS = 0;
    localparam int RX_COIN   = 1;
    localparam int RX_CHOKE  = 2;
    localparam int RX_CYCLE  = 3;

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic cmd_valid = 1'b0;
    logic cmd_ready;
    t_in  cmd_item  = '0;
    logic res_valid;
    logic res_ready = 1'b0;
    t_out res_item;

    int errors, pending, results, full_drops, empty_pops, full_steps, clears;
    int sent_items;
    int burst_left   = 0;
    int idle_cycles  = 0;
    int ready_mode   = RX_ALWAYS;
    int mode_left    = 0;
    int hold_left    = 0;
    int rx_tick      = 0;

    double_ended_queue_core u_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_valid (cmd_valid),
        .o_ready (cmd_ready),
        .i_data  (cmd_item),
        .o_valid (res_valid),
        .i_ready (res_ready),
        .o_data  (res_item)
    );

    double_ended_queue_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cmd_valid  (cmd_valid),
        .i_cmd_ready  (cmd_ready),
        .i_cmd_item   (cmd_item),
        .i_res_valid  (res_valid),
        .i_res_ready  (res_ready),
        .i_res_item   (res_item),
        .o_errors     (errors),
        .o_pending    (pending),
        .o_results    (results),
        .o_full_drops (full_drops),
        .o_empty_pops (empty_pops),
        .o_full_steps (full_steps),
        .o_clears     (clears)
    );

    initial begin
        forever #4 clk = ~clk;
    end

    // result side: stall pattern switches between randomly chosen modes
    always @(posedge clk) begin
        rx_tick <= rx_tick + 1;
        if (mode_left == 0) begin
            ready_mode <= $urandom_range(RX_ALWAYS, RX_CYCLE);
            mode_left  <= $urandom_range(20, 150);
        end else begin
            mode_left <= mode_left - 1;
        end
        case (ready_mode)
            RX_ALWAYS: res_ready <= 1'b1;
            RX_COIN:   res_ready <= 1'($urandom_range(0, 1));
            RX_CHOKE: begin
                if (hold_left == 0) begin
                    res_ready <= 1'b1;
                    hold_left <= $urandom_range(1, 30);
                end else begin
                    res_ready <= 1'b0;
                    hold_left <= hold_left - 1;
                end
            end
            default: res_ready <= (rx_tick % 3) != 0;
        endcase
    end

    always @(posedge clk) begin
        if (!rst_n || (cmd_valid && cmd_ready) || (res_valid && res_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("ERROR: no item moved for %0d cycles", WATCHDOG_LIMIT);
            $display("*** FAILED ***");
            $finish;
        end
    end

    function automatic logic signed [VALUE_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0:       return INT_MIN;
            1:       return INT_MAX;
            2:       return '0;
            3:       return '1;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [2:0] pick_command(input int bias);
        int roll;
        int push_pct;
        roll     = $urandom_range(0, 99);
        push_pct = (bias == BIAS_FILL) ? 70 : (bias == BIAS_DRAIN) ? 25 : 50;
        if (roll < 2) return CMD_CLEAR;
        if (roll < 3) return CMD_NONE;
        if (roll < 5) return $urandom_range(0, 1) ? CMD_SPARE_6 : CMD_SPARE_7;
        if ($urandom_range(0, 99) < push_pct)
            return $urandom_range(0, 1) ? CMD_PUSH_FRONT : CMD_PUSH_REAR;
        return $urandom_range(0, 1) ? CMD_POP_FRONT : CMD_POP_REAR;
    endfunction

    // holds valid until the item is taken, then maybe idles between bursts
    task automatic send_cmd(input logic [2:0] command, input logic signed [VALUE_W-1:0] value);
        t_in item;
        int  gap;
        item.command = command;
        item.value   = value;
        cmd_valid <= 1'b1;
        cmd_item  <= item;
        do @(posedge clk); while (!cmd_ready);
        sent_items++;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(60, 120)
                                                     : $urandom_range(1, 16);
            gap = $urandom_range(0, 12);
            if (gap > 0) begin
                cmd_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    initial begin
        int directed_items;
        int bias;
        int phase_len;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // corner cases on an empty deque
        send_cmd(CMD_POP_FRONT, pick_value());
        send_cmd(CMD_POP_REAR, pick_value());
        send_cmd(CMD_CLEAR, pick_value());
        send_cmd(CMD_NONE, INT_MAX);
        send_cmd(CMD_SPARE_6, '1);
        send_cmd(CMD_SPARE_7, INT_MIN);
        // popping the only value from either end
        send_cmd(CMD_PUSH_REAR, INT_MIN);
        send_cmd(CMD_POP_REAR, '0);
        send_cmd(CMD_PUSH_FRONT, INT_MAX);
        send_cmd(CMD_POP_FRONT, '0);
        // fill from both ends, then overflow both ends
        send_cmd(CMD_PUSH_FRONT, '0);
        send_cmd(CMD_PUSH_REAR, '1);
        for (int k = 0; k < CAPACITY - 2; k++)
            send_cmd(k[0] ? CMD_PUSH_FRONT : CMD_PUSH_REAR, pick_value());
        send_cmd(CMD_PUSH_REAR, INT_MAX);
        send_cmd(CMD_PUSH_FRONT, INT_MIN);
        send_cmd(CMD_CLEAR, '0);
        directed_items = sent_items;

        while (sent_items < TOTAL_ITEMS) begin
            bias      = $urandom_range(BIAS_FILL, BIAS_MIXED);
            phase_len = $urandom_range(8, 48);
            repeat (phase_len) begin
                if (sent_items < TOTAL_ITEMS)
                    send_cmd(pick_command(bias), pick_value());
            end
        end

        cmd_valid <= 1'b0;
        // one more edge so the checker has queued the last accepted item
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d commands (%0d directed), checked %0d results, %0d clears.",
                 sent_items, directed_items, results, clears);
        $display("Pushes dropped at full: %0d, pops on empty: %0d, steps ending full: %0d.",
                 full_drops, empty_pops, full_steps);
        if (errors == 0 && pending == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
`default_nettype wire
